### rtl/core/sbid_pkg.sv
// Package with the format codes, the decode patterns and the result type of the decoder.
package sbid_pkg;

   // Width of one instruction halfword.
   localparam int unsigned InsnWidth = 16;

   // Format codes in their numbered order.
   typedef enum logic [4:0] {
      FMT_MOVE_SHIFTED   = 5'd0,
      FMT_ADD_SUB        = 5'd1,
      FMT_MOVE_IMM       = 5'd2,
      FMT_ALU            = 5'd3,
      FMT_HI_REG         = 5'd4,
      FMT_PC_LOAD        = 5'd5,
      FMT_LS_REG_OFFSET  = 5'd6,
      FMT_LS_SIGN_EXT    = 5'd7,
      FMT_LS_IMM_OFFSET  = 5'd8,
      FMT_LS_HALF        = 5'd9,
      FMT_SP_LS          = 5'd10,
      FMT_LOAD_ADDR      = 5'd11,
      FMT_ADD_SP         = 5'd12,
      FMT_PUSH_POP       = 5'd13,
      FMT_MULTI_LS       = 5'd14,
      FMT_COND_BRANCH    = 5'd15,
      FMT_SOFT_INT       = 5'd16,
      FMT_BRANCH         = 5'd17,
      FMT_LONG_BRANCH    = 5'd18,
      FMT_UNDEFINED      = 5'd19
   } format_type;

   // Mask and match pairs, listed in decode priority order.
   localparam logic [15:0] MaskAddSp      = 16'hFF00;
   localparam logic [15:0] MatchAddSp     = 16'hB000;
   localparam logic [15:0] MaskMultiLs    = 16'hF000;
   localparam logic [15:0] MatchMultiLs   = 16'hC000;
   localparam logic [15:0] MaskPushPop    = 16'hF600;
   localparam logic [15:0] MatchPushPop   = 16'hB400;
   localparam logic [15:0] MaskSpLs       = 16'hF000;
   localparam logic [15:0] MatchSpLs      = 16'h9000;
   localparam logic [15:0] MaskLsHalf     = 16'hF000;
   localparam logic [15:0] MatchLsHalf    = 16'h8000;
   localparam logic [15:0] MaskLsImm      = 16'hE000;
   localparam logic [15:0] MatchLsImm     = 16'h6000;
   localparam logic [15:0] MaskLsReg      = 16'hF200;
   localparam logic [15:0] MatchLsReg     = 16'h5000;
   localparam logic [15:0] MaskLsSign     = 16'hF200;
   localparam logic [15:0] MatchLsSign    = 16'h5200;
   localparam logic [15:0] MaskSoftInt    = 16'hFF00;
   localparam logic [15:0] MatchSoftInt   = 16'hDF00;
   localparam logic [15:0] MaskCondBr     = 16'hF000;
   localparam logic [15:0] MatchCondBr    = 16'hD000;
   localparam logic [15:0] MaskBranch     = 16'hF800;
   localparam logic [15:0] MatchBranch    = 16'hE000;
   localparam logic [15:0] MaskLongBr     = 16'hF000;
   localparam logic [15:0] MatchLongBr    = 16'hF000;
   localparam logic [15:0] MaskHiReg      = 16'hFC00;
   localparam logic [15:0] MatchHiReg     = 16'h4400;
   localparam logic [15:0] MaskMoveImm    = 16'hE000;
   localparam logic [15:0] MatchMoveImm   = 16'h2000;
   localparam logic [15:0] MaskAddSub     = 16'hF800;
   localparam logic [15:0] MatchAddSub    = 16'h1800;
   localparam logic [15:0] MaskMoveShift  = 16'hE000;
   localparam logic [15:0] MatchMoveShift = 16'h0000;
   localparam logic [15:0] MaskAlu        = 16'hFC00;
   localparam logic [15:0] MatchAlu       = 16'h4000;
   localparam logic [15:0] MaskPcLoad     = 16'hF800;
   localparam logic [15:0] MatchPcLoad    = 16'h4800;
   localparam logic [15:0] MaskLoadAddr   = 16'hF000;
   localparam logic [15:0] MatchLoadAddr  = 16'hA000;

   // One decoded result word.
   typedef struct packed {
      logic       source_high;
      logic       dest_high;
      logic       second_half_flag;
      logic       extra_reg_flag;
      logic       sp_base_flag;
      logic       sign_flag;
      logic       immediate_flag;
      logic       byte_flag;
      logic       half_flag;
      logic       load_flag;
      logic [3:0] op_field;
      format_type format_class;
   } decode_type;

   // Result word width and its byte-padded bus width.
   localparam int unsigned DecodeWidth = $bits(decode_type);
   localparam int unsigned RspWidth    = ((DecodeWidth + 7) / 8) * 8;

endpackage

### rtl/core/sixteen_bit_instruction_decoder_unit.sv
// Top level of the sixteen-bit instruction decoder: input register, decode logic, result register.
// An accepted word is held in the input register and decoded, and the result register
// captures the decoded word, which it offers on the result port.
// Throughput: one word per cycle; the input register and the result register both
// advance whenever the result register is empty or being taken.
// Backpressure on the result port stops both registers; the input side then fills once.
// Reset: synchronous, active high; it empties both registers and holds no other state.
module sixteen_bit_instruction_decoder_unit
   import sbid_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic [15:0]         req_tdata,   // [15:0] instruction
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [RspWidth-1:0] rsp_tdata    // [4:0] format_class, [8:5] op_field,
                                             // [9] load_flag, [10] half_flag,
                                             // [11] byte_flag, [12] immediate_flag,
                                             // [13] sign_flag, [14] sp_base_flag,
                                             // [15] extra_reg_flag, [16] second_half_flag,
                                             // [17] dest_high, [18] source_high, rest zero
);

   logic                 insn_valid_ff;
   logic                 insn_valid_in;
   logic [InsnWidth-1:0] insn_ff;
   logic                 rsp_valid_ff;
   logic                 rsp_valid_in;
   decode_type           rsp_ff;
   decode_type           decode_in;
   format_type           fmt;
   logic                 rsp_load;

   // The result register loads when it is empty or its word is taken.
   assign rsp_load     = !rsp_valid_ff || rsp_tready;
   assign req_tready   = !insn_valid_ff || rsp_load;
   assign insn_valid_in = req_tready ? req_tvalid : insn_valid_ff;
   assign rsp_valid_in  = rsp_load ? insn_valid_ff : rsp_valid_ff;

   // Valid bits for both registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         insn_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         insn_valid_ff <= insn_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (req_tready) begin
         insn_ff <= req_tdata;
      end
      if (rsp_load) begin
         rsp_ff <= decode_in;
      end
   end

   // Priority classification; the first matching pattern wins.
   always_comb begin
      if ((insn_ff & MaskAddSp) == MatchAddSp) begin
         fmt = FMT_ADD_SP;
      end else if ((insn_ff & MaskMultiLs) == MatchMultiLs) begin
         fmt = FMT_MULTI_LS;
      end else if ((insn_ff & MaskPushPop) == MatchPushPop) begin
         fmt = FMT_PUSH_POP;
      end else if ((insn_ff & MaskSpLs) == MatchSpLs) begin
         fmt = FMT_SP_LS;
      end else if ((insn_ff & MaskLsHalf) == MatchLsHalf) begin
         fmt = FMT_LS_HALF;
      end else if ((insn_ff & MaskLsImm) == MatchLsImm) begin
         fmt = FMT_LS_IMM_OFFSET;
      end else if ((insn_ff & MaskLsReg) == MatchLsReg) begin
         fmt = FMT_LS_REG_OFFSET;
      end else if ((insn_ff & MaskLsSign) == MatchLsSign) begin
         fmt = FMT_LS_SIGN_EXT;
      end else if ((insn_ff & MaskSoftInt) == MatchSoftInt) begin
         fmt = FMT_SOFT_INT;
      end else if ((insn_ff & MaskCondBr) == MatchCondBr) begin
         fmt = FMT_COND_BRANCH;
      end else if ((insn_ff & MaskBranch) == MatchBranch) begin
         fmt = FMT_BRANCH;
      end else if ((insn_ff & MaskLongBr) == MatchLongBr) begin
         fmt = FMT_LONG_BRANCH;
      end else if ((insn_ff & MaskHiReg) == MatchHiReg) begin
         fmt = FMT_HI_REG;
      end else if ((insn_ff & MaskMoveImm) == MatchMoveImm) begin
         fmt = FMT_MOVE_IMM;
      end else if ((insn_ff & MaskAddSub) == MatchAddSub) begin
         fmt = FMT_ADD_SUB;
      end else if ((insn_ff & MaskMoveShift) == MatchMoveShift) begin
         fmt = FMT_MOVE_SHIFTED;
      end else if ((insn_ff & MaskAlu) == MatchAlu) begin
         fmt = FMT_ALU;
      end else if ((insn_ff & MaskPcLoad) == MatchPcLoad) begin
         fmt = FMT_PC_LOAD;
      end else if ((insn_ff & MaskLoadAddr) == MatchLoadAddr) begin
         fmt = FMT_LOAD_ADDR;
      end else begin
         fmt = FMT_UNDEFINED;
      end
   end

   // Field extraction; fields a format does not define stay zero.
   always_comb begin
      decode_in              = '0;
      decode_in.format_class = fmt;
      case (fmt)
         FMT_MOVE_SHIFTED, FMT_MOVE_IMM: begin
            decode_in.op_field = {2'b00, insn_ff[12:11]};
         end
         FMT_ADD_SUB: begin
            decode_in.op_field       = {3'b000, insn_ff[9]};
            decode_in.immediate_flag = insn_ff[10];
         end
         FMT_ALU: begin
            decode_in.op_field = insn_ff[9:6];
         end
         FMT_HI_REG: begin
            decode_in.op_field    = {2'b00, insn_ff[9:8]};
            decode_in.dest_high   = insn_ff[7];
            decode_in.source_high = insn_ff[6];
         end
         FMT_LS_REG_OFFSET: begin
            decode_in.load_flag = insn_ff[11];
            decode_in.byte_flag = insn_ff[10];
         end
         FMT_LS_SIGN_EXT: begin
            decode_in.half_flag = insn_ff[11];
            decode_in.sign_flag = insn_ff[10];
         end
         FMT_LS_IMM_OFFSET: begin
            decode_in.load_flag = insn_ff[11];
            decode_in.byte_flag = insn_ff[12];
         end
         FMT_LS_HALF, FMT_SP_LS, FMT_MULTI_LS: begin
            decode_in.load_flag = insn_ff[11];
         end
         FMT_LOAD_ADDR: begin
            decode_in.sp_base_flag = insn_ff[11];
         end
         FMT_ADD_SP: begin
            decode_in.sign_flag = insn_ff[7];
         end
         FMT_PUSH_POP: begin
            decode_in.load_flag      = insn_ff[11];
            decode_in.extra_reg_flag = insn_ff[8];
         end
         FMT_LONG_BRANCH: begin
            decode_in.second_half_flag = insn_ff[11];
         end
         default: begin
            decode_in.op_field = 4'd0;
         end
      endcase
   end

   // Result port.
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RspWidth - DecodeWidth){1'b0}}, rsp_ff};

`ifndef SYNTHESIS
   // A held input word that moves forward must show on the result port next cycle.
   assert property (@(posedge clock) disable iff (reset)
      (insn_valid_ff && rsp_load) |=> rsp_tvalid)
      else $error("decoded word lost between input and result register");

   // The input side never takes a word while its register is full and blocked.
   assert property (@(posedge clock) disable iff (reset)
      (insn_valid_ff && rsp_valid_ff && !rsp_tready) |-> !req_tready)
      else $error("input register overwritten while stalled");

   // An undefined halfword carries no operation or flag bits.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_ff.format_class == FMT_UNDEFINED) |-> (rsp_tdata[18:5] == 14'd0))
      else $error("undefined format with nonzero fields");

   // The format code never leaves its defined range.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[4:0] <= 5'd19))
      else $error("format code out of range");
`endif

endmodule
